[hdl/jsu_pkg.sv]
// Shared types, character codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

   // Bytes one input character can cause at most
   localparam int MAX_BYTES   = 6;
   // Default depth of the queue between decoder and byte emitter
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LO_B   = 8'h62;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] CHAR_LO_N   = 8'h6E;
   localparam logic [7:0] CHAR_LO_R   = 8'h72;
   localparam logic [7:0] CHAR_LO_T   = 8'h74;
   localparam logic [7:0] CHAR_LO_U   = 8'h75;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   // One decoded character: its output bytes, how many, and end of string
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      last;
   } burst_type;

   // Hex digit value 0..15, bit 4 set for a non-hex character
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = {1'b0, c[3:0] + 4'd9};
      else                               v = 5'h10;
      return v;
   endfunction

endpackage

[hdl/jsu_front.sv]
// Front end: accepts characters, tracks escape state and builds byte bursts.
`timescale 1ns / 1ps

module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       req_full,
   input  logic       q_full,
   output logic       q_push,
   output burst_type  q_data
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;

   logic [1:0] mode_ff, mode_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] store_ff [3];
   logic [7:0] store_in [3];
   logic       accept;
   logic       as_normal;
   logic [4:0] hv;
   logic [4:0] hv0, hv1, hv2;
   logic [15:0] code;
   logic [MAX_BYTES-1:0][7:0] b;
   logic [2:0] n;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign hv       = hex_value(req_in_char);
   assign hv0      = hex_value(store_ff[0]);
   assign hv1      = hex_value(store_ff[1]);
   assign hv2      = hex_value(store_ff[2]);
   assign code     = {hv0[3:0], hv1[3:0], hv2[3:0], hv[3:0]};

   // Decode one character into a burst of bytes and the next state
   always_comb begin
      b         = '0;
      n         = 3'd0;
      mode_in   = mode_ff;
      count_in  = count_ff;
      store_in  = store_ff;
      as_normal = 1'b0;
      unique case (mode_ff)
         MODE_ESCAPE: begin
            mode_in = MODE_NORMAL;
            n       = 3'd1;
            unique case (req_in_char)
               CHAR_QUOTE:  b[0] = CHAR_QUOTE;
               CHAR_BSLASH: b[0] = CHAR_BSLASH;
               CHAR_SLASH:  b[0] = CHAR_SLASH;
               CHAR_LO_B:   b[0] = CHAR_BS;
               CHAR_LO_F:   b[0] = CHAR_FF;
               CHAR_LO_N:   b[0] = CHAR_LF;
               CHAR_LO_R:   b[0] = CHAR_CR;
               CHAR_LO_T:   b[0] = CHAR_TAB;
               CHAR_LO_U: begin
                  mode_in  = MODE_HEX;
                  count_in = 2'd0;
                  n        = 3'd0;
               end
               default: begin
                  // unknown escape passes through literally
                  b[0] = CHAR_BSLASH;
                  b[1] = req_in_char;
                  n    = 3'd2;
               end
            endcase
         end
         MODE_HEX: begin
            if (hv[4]) begin
               // bad digit: flush what was gathered, then reprocess the character
               b[0]      = CHAR_BSLASH;
               b[1]      = CHAR_LO_U;
               b[2]      = store_ff[0];
               b[3]      = store_ff[1];
               b[4]      = store_ff[2];
               n         = 3'd2 + {1'b0, count_ff};
               mode_in   = MODE_NORMAL;
               count_in  = 2'd0;
               as_normal = 1'b1;
            end else if (count_ff != 2'd3) begin
               store_in[count_ff] = req_in_char;
               count_in           = count_ff + 2'd1;
            end else begin
               // fourth digit: encode the code point as UTF-8
               mode_in  = MODE_NORMAL;
               count_in = 2'd0;
               if (code < 16'h0080) begin
                  b[0] = code[7:0];
                  n    = 3'd1;
               end else if (code < 16'h0800) begin
                  b[0] = {3'b110, code[10:6]};
                  b[1] = {2'b10, code[5:0]};
                  n    = 3'd2;
               end else begin
                  b[0] = {4'b1110, code[15:12]};
                  b[1] = {2'b10, code[11:6]};
                  b[2] = {2'b10, code[5:0]};
                  n    = 3'd3;
               end
            end
         end
         default: as_normal = 1'b1;
      endcase

      // Ordinary character handling, appended after any flush
      if (as_normal) begin
         if (req_in_char == CHAR_BSLASH) begin
            mode_in = MODE_ESCAPE;
         end else begin
            b[n] = req_in_char;
            n    = n + 3'd1;
         end
      end

      // End of string: flush an open \u, drop a lone backslash
      if (req_in_last) begin
         if (mode_in == MODE_HEX) begin
            b[0] = CHAR_BSLASH;
            b[1] = CHAR_LO_U;
            b[2] = store_in[0];
            b[3] = store_in[1];
            b[4] = store_in[2];
            n    = 3'd2 + {1'b0, count_in};
         end
         mode_in  = MODE_NORMAL;
         count_in = 2'd0;
      end
   end

   assign q_data.bytes = b;
   assign q_data.count = n;
   assign q_data.last  = req_in_last;
   assign q_push       = accept && (n != 3'd0 || req_in_last);

   // Advance decode state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         count_ff <= 2'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Hold gathered hex digits
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> mode_ff == MODE_NORMAL && count_ff == 2'd0)
      else $error("decode state not cleared after end of string");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_data.count <= 3'(MAX_BYTES))
      else $error("burst longer than the byte limit");

   a_hex_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_HEX |-> count_ff == 2'd0)
      else $error("digit count left over outside a hex escape");

endmodule

[hdl/jsu_queue.sv]
// Short queue of decoded bursts between the front end and the byte emitter.
`timescale 1ns / 1ps

module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  burst_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output burst_type rd_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic              do_wr, do_rd;

   assign full    = fill_ff == CNT_W'(DEPTH);
   assign empty   = fill_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd)      fill_ff <= fill_ff + 1'b1;
         else if (do_rd && !do_wr) fill_ff <= fill_ff - 1'b1;
      end
   end

   // Store written bursts
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("queue fill above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("burst popped from empty queue");

endmodule

[hdl/jsu_back.sv]
// Back end: walks each burst and presents one output byte at a time.
`timescale 1ns / 1ps

module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  burst_type  q_data,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_end_of_string
);

   logic [2:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bvalid_ff, run_last_ff, eos_ff;
   logic       advance, is_bare, at_end;

   assign advance = !q_empty && (!valid_ff || rsp_pop);
   assign is_bare = q_data.count == 3'd0;
   assign at_end  = is_bare || (idx_ff == q_data.count - 3'd1);
   assign q_pop   = advance && at_end;

   // Step through the bytes of the head burst
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            idx_ff <= at_end ? 3'd0 : idx_ff + 3'd1;
         end
         if (advance)      valid_ff <= 1'b1;
         else if (rsp_pop) valid_ff <= 1'b0;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff     <= is_bare ? 8'd0 : q_data.bytes[idx_ff];
         bvalid_ff   <= !is_bare;
         run_last_ff <= at_end;
         eos_ff      <= at_end && q_data.last;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_run_last      = run_last_ff;
   assign rsp_end_of_string = eos_ff;

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      !q_empty && !is_bare |-> idx_ff < q_data.count)
      else $error("byte index beyond burst length");

   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> idx_ff == 3'd0)
      else $error("byte index not rewound after burst");

endmodule

[hdl/json_string_unescape.sv]
// Top level of the JSON string unescaper.
`timescale 1ns / 1ps

// Takes the characters of a JSON string body one per item and returns the
// unescaped bytes, UTF-8 for \uXXXX, with run_last on the final byte of each
// character and end_of_string on the final byte of the string. A character
// that yields at most one byte is taken every cycle while req_full is low; one
// that yields k bytes holds the single-byte output register for each of its k
// bytes in turn, and the decoder runs ahead by up to QUEUE_DEPTH_P bursts
// before req_full rises. A byte passes through the burst queue and then the
// output register before it shows on the result side and can be popped.

module json_string_unescape
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_end_of_string
);

   burst_type wr_data, rd_data;
   logic      q_push, q_full, q_pop, q_empty;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_char (req_in_char),
      .req_in_last (req_in_last),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (wr_data)
   );

   jsu_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (rd_data),
      .empty   (q_empty)
   );

   jsu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (rd_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_run_last      (rsp_run_last),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule
